/* sv/sts_pkg.sv */
// Package for the symbol table store: sizes, request kinds, result codes,
// controller states and the command/status structs between control and datapath.
// No dependencies.
`default_nettype none
package sts_pkg;
	localparam int CAPACITY = 64;
	localparam int NAME_W   = 48;
	localparam int LOC_W    = 20;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_DUMP   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic latch;
		logic start;
		logic issue;
		logic emit;
	} cmd_t;

	typedef struct packed {
		kind_t            kind;
		logic             scan_done;
		logic             rd_pending;
		logic             slot_free;
		logic             dump_last;
		logic             count_zero;
		logic [CNT_W-1:0] count;
	} stat_t;
endpackage
`default_nettype wire

/* sv/sts_dp.sv */
// Datapath of the symbol table store: entry memory, scan counter, best-candidate
// registers and the output register. Depends on sts_pkg.
`default_nettype none
module sts_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sts_pkg::cmd_t         cmd,
	output sts_pkg::stat_t             stat,
	input  wire logic [1:0]            kind,
	input  wire logic [47:0]           name,
	input  wire logic [19:0]           location,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 status,
	output logic [47:0]                found_name,
	output logic [19:0]                found_location,
	output logic                       last
);
	import sts_pkg::*;

	logic [NAME_W-1:0] mem_name [CAPACITY];
	logic [LOC_W-1:0]  mem_loc  [CAPACITY];

	kind_t             kind_q;
	logic [NAME_W-1:0] name_q;
	logic [LOC_W-1:0]  loc_q;
	logic [CNT_W-1:0]  count_q, idx_q, emit_q;
	logic              rv_q;
	logic [NAME_W-1:0] rd_name_s1;
	logic [LOC_W-1:0]  rd_loc_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic              best_valid_q, have_prev_q;
	logic [NAME_W-1:0] best_name_q, prev_name_q;
	logic [LOC_W-1:0]  best_loc_q;
	logic [IDX_W-1:0]  best_idx_q, prev_idx_q;
	logic              take;
	logic              after_prev;

	always_comb begin
		after_prev = !have_prev_q || (rd_name_s1 < prev_name_q) ||
			((rd_name_s1 == prev_name_q) && (rd_idx_s1 > prev_idx_q));
		if (kind_q == KIND_LOOKUP) begin
			take = rv_q && !best_valid_q && (rd_name_s1 == name_q);
		end else begin
			// Strictly greater keeps the earlier index among equal names.
			take = rv_q && after_prev && (!best_valid_q || rd_name_s1 > best_name_q);
		end
	end

	assign stat.kind       = kind_q;
	assign stat.scan_done  = (idx_q == count_q);
	assign stat.rd_pending = rv_q;
	assign stat.slot_free  = !out_valid || out_ready;
	assign stat.dump_last  = ((emit_q + 1'b1) == count_q);
	assign stat.count_zero = (count_q == '0);
	assign stat.count      = count_q;

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_name_s1 <= mem_name[idx_q[IDX_W-1:0]];
			rd_loc_s1  <= mem_loc[idx_q[IDX_W-1:0]];
			rd_idx_s1  <= idx_q[IDX_W-1:0];
		end
		if (cmd.emit && kind_q == KIND_INSERT && count_q != CNT_W'(CAPACITY)) begin
			mem_name[count_q[IDX_W-1:0]] <= name_q;
			mem_loc[count_q[IDX_W-1:0]]  <= loc_q;
		end
		if (cmd.latch) begin
			kind_q <= kind_t'(kind);
			name_q <= name;
			loc_q  <= location;
		end
		if (take) begin
			best_name_q <= rd_name_s1;
			best_loc_q  <= rd_loc_s1;
			best_idx_q  <= rd_idx_s1;
		end
		if (cmd.emit) begin
			prev_name_q <= best_name_q;
			prev_idx_q  <= best_idx_q;
			unique case (kind_q)
				KIND_CLEAR, KIND_INSERT: begin
					status         <= (kind_q == KIND_INSERT && count_q == CNT_W'(CAPACITY))
						? ST_FULL : ST_OK;
					found_name     <= name_q;
					found_location <= '0;
					last           <= 1'b1;
				end
				KIND_LOOKUP: begin
					status         <= best_valid_q ? ST_OK : ST_NOTFOUND;
					found_name     <= name_q;
					found_location <= best_valid_q ? best_loc_q : '0;
					last           <= 1'b1;
				end
				KIND_DUMP: begin
					if (count_q == '0) begin
						status         <= ST_EMPTY;
						found_name     <= name_q;
						found_location <= '0;
						last           <= 1'b1;
					end else begin
						status         <= ST_OK;
						found_name     <= best_name_q;
						found_location <= best_loc_q;
						last           <= ((emit_q + 1'b1) == count_q);
					end
				end
				default: begin
					status <= ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			idx_q        <= '0;
			emit_q       <= '0;
			rv_q         <= 1'b0;
			best_valid_q <= 1'b0;
			have_prev_q  <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			rv_q <= cmd.issue;
			if (cmd.latch) begin
				have_prev_q <= 1'b0;
				emit_q      <= '0;
			end
			if (cmd.start) begin
				idx_q        <= '0;
				best_valid_q <= 1'b0;
			end else if (take) begin
				best_valid_q <= 1'b1;
			end
			if (cmd.issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid   <= 1'b1;
				have_prev_q <= 1'b1;
				emit_q      <= emit_q + 1'b1;
				if (kind_q == KIND_CLEAR) begin
					count_q <= '0;
				end else if (kind_q == KIND_INSERT && count_q != CNT_W'(CAPACITY)) begin
					count_q <= count_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

/* sv/sts_ctl.sv */
// Controller of the symbol table store: sequences latch, scan passes and result
// pushes. Depends on sts_pkg.
`default_nettype none
module sts_ctl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire sts_pkg::stat_t stat,
	output sts_pkg::cmd_t       cmd,
	output sts_pkg::state_t     state
);
	import sts_pkg::*;

	state_t state_q, state_d;

	assign state = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_START;
				end
			end
			S_START: begin
				cmd.start = 1'b1;
				if (stat.kind == KIND_CLEAR || stat.kind == KIND_INSERT ||
						(stat.kind == KIND_DUMP && stat.count_zero)) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!stat.scan_done) begin
					cmd.issue = 1'b1;
				end else if (!stat.rd_pending) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					// Each dumped entry needs a fresh pass to find its successor.
					if (stat.kind == KIND_DUMP && !stat.count_zero && !stat.dump_last) begin
						state_d = S_START;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

/* sv/symbol_table_store.sv */
// Symbol table store. A request (in_valid/in_ready) carries kind, name and
// location; results leave on out_valid/out_ready with status, found_name,
// found_location and last. Every request yields at least one result, and
// last marks the final one. Requests are handled one at a time.
// Clear and insert pass from acceptance through the start state straight to
// the result push, with no scan. Lookup scans the stored entries through the
// single memory read port, one per cycle. A dump finds each output entry with
// a new full pass over the stored entries, through the same read port.
// Reset empties the table; entry contents are not cleared, since only entries
// below the count are ever read. No clearing pass is needed.
// The output register holds a result until it is taken; a stalled receiver
// holds the controller in its push state, and a new request is taken as soon
// as the previous request's final result sits in the output register.
// Depends on sts_pkg, sts_ctl and sts_dp.
`default_nettype none
module symbol_table_store (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [47:0] name,
	input  wire logic [19:0] location,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [47:0]      found_name,
	output logic [19:0]      found_location,
	output logic             last
);
	import sts_pkg::*;

	cmd_t   cmd;
	stat_t  stat;
	state_t state;

	sts_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd),
		.state    (state)
	);

	sts_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.kind           (kind),
		.name           (name),
		.location       (location),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.found_name     (found_name),
		.found_location (found_location),
		.last           (last)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in progress");

	a_push_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> state == S_EMIT && stat.slot_free)
		else $error("result pushed outside the push state or over a held result");
endmodule
`default_nettype wire
